// ===== src/tspc_pkg.sv =====
// shared types, constants and helper functions for the temperature polynomial conversion unit
package tspc_pkg;

    // item field widths
    localparam int SENSOR_W = 3;
    localparam int IDX_W    = 3;
    localparam int COEF_W   = 16;
    localparam int ADC_W    = 24;
    localparam int A_W      = 16;
    localparam int TEMP_W   = 16;

    // calibration store geometry
    localparam int SENSORS = 8;
    localparam int COEFS   = 5;
    localparam int DEPTH   = SENSORS * COEFS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // datapath widths
    localparam int CHUNK_W = 32;
    localparam int ACC_W   = 3 * CHUNK_W;
    localparam int PROD_W  = CHUNK_W + COEF_W;
    localparam int SCALE_W = 2 * CHUNK_W;
    localparam int Q_W     = 17;

    // reciprocal divide: 1e19 = 5^19 * 2^19, quotient estimated from the top bits
    localparam int Y_LSB       = 19;
    localparam int Y_W         = 62;
    localparam int YT_LSB      = Y_LSB + 30;
    localparam int RECIP_SHIFT = 46;
    localparam int BACK_LO_W   = Q_W + CHUNK_W;
    localparam int BACK_HI_W   = Q_W + COEF_W;

    // sequencer counts
    localparam int STEP_W = 3;
    localparam int PHASE_W = 3;
    localparam logic [STEP_W-1:0]  STEP_TOP       = STEP_W'(COEFS - 1);
    localparam logic [PHASE_W-1:0] PHASE_FIRST    = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PHASE_COEF     = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] PHASE_LAST_MUL = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PHASE_LAST     = PHASE_W'(5);

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // multiplier operand source
    localparam logic SRC_ACC  = 1'b0;
    localparam logic SRC_COEF = 1'b1;

    // word chunks of the accumulator and scale constants
    localparam logic [1:0] CHUNK_LO  = 2'd0;
    localparam logic [1:0] CHUNK_MID = 2'd1;
    localparam logic [1:0] CHUNK_HI  = 2'd2;

    // rounding and division constants
    localparam logic [SCALE_W-1:0] DIVISOR    = 64'd10000000000000000000;
    localparam logic [SCALE_W-1:0] ROUND_HALF = 64'd5000000000000000000;
    localparam logic [SCALE_W-1:0] DIV_ODD    = 64'd19073486328125;
    localparam logic [CHUNK_W-1:0] DIV_ODD_LO = DIV_ODD[CHUNK_W-1:0];
    localparam logic [COEF_W-1:0]  DIV_ODD_HI = DIV_ODD[CHUNK_W +: COEF_W];
    // floor(2^76 / 5^19)
    localparam logic [CHUNK_W-1:0] RECIP      = 32'd3961408125;
    localparam logic [Q_W-1:0] TEMP_MAX_MAG = Q_W'(2 ** (TEMP_W - 1) - 1);
    localparam logic [Q_W-1:0] TEMP_MIN_MAG = Q_W'(2 ** (TEMP_W - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POLY,
        ST_ABS,
        ST_OVCHK,
        ST_RECIP,
        ST_BACK,
        ST_FIX,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic              start;
        logic              rd_en;
        logic [STEP_W-1:0] step;
        logic              mul_en;
        logic              mul_src;
        logic [1:0]        chunk;
        logic              clear;
        logic              neg;
        logic              last;
        logic              abs_en;
        logic              ovchk_en;
        logic              recip_en;
        logic              back_en;
        logic              fix_en;
        logic              out_load;
    } tspc_cmd_t;

    // scale of calibration word k[step] in the polynomial
    function automatic logic [SCALE_W-1:0] coef_scale(input logic [STEP_W-1:0] step);
        logic [SCALE_W-1:0] s;
        case (step)
            3'd0:    s = 64'd15000000000000000000;
            3'd1:    s = 64'd1000000000000000;
            3'd2:    s = 64'd20000000000;
            3'd3:    s = 64'd400000;
            3'd4:    s = 64'd2;
            default: s = '0;
        endcase
        return s;
    endfunction

    // terms for k0, k2 and k4 are subtracted
    function automatic logic scale_is_negative(input logic [STEP_W-1:0] step);
        return ~step[0];
    endfunction

    function automatic logic sensor_in_range(input logic [SENSOR_W-1:0] sensor);
        return 32'(sensor) < SENSORS;
    endfunction

    function automatic logic [ADDR_W-1:0] coef_addr(input logic [SENSOR_W-1:0] sensor,
                                                    input logic [IDX_W-1:0] index);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(sensor) * ADDR_W'(COEFS);
        return base + ADDR_W'(index);
    endfunction

endpackage

// ===== src/tspc_coef_store.sv =====
// calibration word memory with per-entry valid bits cleared at reset
module tspc_coef_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [tspc_pkg::SENSOR_W-1:0]  wr_sensor,
    input  logic [tspc_pkg::IDX_W-1:0]     wr_index,
    input  logic [tspc_pkg::COEF_W-1:0]    wr_value,
    input  logic                           rd_en,
    input  logic [tspc_pkg::SENSOR_W-1:0]  rd_sensor,
    input  logic [tspc_pkg::IDX_W-1:0]     rd_index,
    output logic [tspc_pkg::COEF_W-1:0]    rd_data
);

    logic [tspc_pkg::COEF_W-1:0] mem [tspc_pkg::DEPTH];
    logic [tspc_pkg::DEPTH-1:0]  vld_reg;
    logic [tspc_pkg::COEF_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic [tspc_pkg::ADDR_W-1:0] wr_addr;
    logic [tspc_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_ok;
    logic                        rd_ok;

    assign wr_addr = tspc_pkg::coef_addr(wr_sensor, wr_index);
    assign rd_addr = tspc_pkg::coef_addr(rd_sensor, rd_index);
    assign wr_ok   = wr_en && tspc_pkg::sensor_in_range(wr_sensor)
                     && (32'(wr_index) < tspc_pkg::COEFS);
    assign rd_ok   = tspc_pkg::sensor_in_range(rd_sensor)
                     && (32'(rd_index) < tspc_pkg::COEFS);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= rd_ok && vld_reg[rd_addr];
            end
        end
    end

    // entries never written read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== src/tspc_datapath.sv =====
// horner evaluation on a shared 32x16 multiplier, reciprocal rounding divide and saturation
module tspc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tspc_pkg::tspc_cmd_t                 cmd,
    input  logic [tspc_pkg::SENSOR_W-1:0]       in_sensor,
    input  logic [tspc_pkg::ADC_W-1:0]          in_reading,
    input  logic [tspc_pkg::COEF_W-1:0]         coef,
    output logic [tspc_pkg::SENSOR_W-1:0]       cur_sensor,
    output logic [tspc_pkg::SENSOR_W-1:0]       out_sensor,
    output logic signed [tspc_pkg::TEMP_W-1:0]  out_temp,
    output logic                                out_clipped
);

    localparam logic [tspc_pkg::ACC_W-1:0] HALF     = tspc_pkg::ACC_W'(tspc_pkg::ROUND_HALF);
    localparam logic [tspc_pkg::ACC_W-1:0] HALF_P1  = HALF + tspc_pkg::ACC_W'(1);
    localparam logic [tspc_pkg::ACC_W-1:0] DIV_LIMIT =
        tspc_pkg::ACC_W'(tspc_pkg::DIVISOR) << tspc_pkg::Q_W;

    logic [tspc_pkg::SENSOR_W-1:0] sensor_reg;
    logic [tspc_pkg::A_W-1:0]      a_reg;
    logic [tspc_pkg::ACC_W-1:0]    acc_reg;
    logic [tspc_pkg::ACC_W-1:0]    sum_reg;
    logic [tspc_pkg::PROD_W-1:0]   prod_reg;
    logic                          add_en_reg;
    logic                          add_clear_reg;
    logic                          add_neg_reg;
    logic                          add_last_reg;
    logic [1:0]                    add_chunk_reg;
    logic [tspc_pkg::ACC_W-1:0]    rem_reg;
    logic [tspc_pkg::BACK_LO_W-1:0] back_lo_reg;
    logic [tspc_pkg::BACK_HI_W-1:0] back_hi_reg;
    logic [tspc_pkg::Q_W-1:0]      q_reg;
    logic                          neg_reg;
    logic                          over_reg;
    logic [tspc_pkg::SENSOR_W-1:0] out_sensor_reg;
    logic [tspc_pkg::TEMP_W-1:0]   out_temp_reg;
    logic                          out_clip_reg;

    logic [tspc_pkg::SCALE_W-1:0]  scale;
    logic [tspc_pkg::CHUNK_W-1:0]  acc_part;
    logic [tspc_pkg::CHUNK_W-1:0]  scale_part;
    logic [tspc_pkg::CHUNK_W-1:0]  mul_a;
    logic [tspc_pkg::COEF_W-1:0]   mul_b;
    logic [tspc_pkg::PROD_W-1:0]   product;
    logic [tspc_pkg::ACC_W-1:0]    term;
    logic [tspc_pkg::ACC_W-1:0]    base;
    logic [tspc_pkg::ACC_W-1:0]    sum_next;
    logic [tspc_pkg::Y_W-1:0]      y_val;
    logic [tspc_pkg::SCALE_W-1:0]  est;
    logic [tspc_pkg::SCALE_W-1:0]  back_next;
    logic                          q_low;
    logic                          clip;
    logic [tspc_pkg::TEMP_W-1:0]   temp;

    assign scale = tspc_pkg::coef_scale(cmd.step);

    always_comb
    begin
        case (cmd.chunk)
            tspc_pkg::CHUNK_LO:
            begin
                acc_part   = acc_reg[0 +: tspc_pkg::CHUNK_W];
                scale_part = scale[0 +: tspc_pkg::CHUNK_W];
            end
            tspc_pkg::CHUNK_MID:
            begin
                acc_part   = acc_reg[tspc_pkg::CHUNK_W +: tspc_pkg::CHUNK_W];
                scale_part = scale[tspc_pkg::CHUNK_W +: tspc_pkg::CHUNK_W];
            end
            tspc_pkg::CHUNK_HI:
            begin
                acc_part   = acc_reg[2 * tspc_pkg::CHUNK_W +: tspc_pkg::CHUNK_W];
                scale_part = '0;
            end
            default:
            begin
                acc_part   = '0;
                scale_part = '0;
            end
        endcase
    end

    assign mul_a   = (cmd.mul_src == tspc_pkg::SRC_COEF) ? scale_part : acc_part;
    assign mul_b   = (cmd.mul_src == tspc_pkg::SRC_COEF) ? coef : a_reg;
    assign product = tspc_pkg::PROD_W'(mul_a) * tspc_pkg::PROD_W'(mul_b);

    // partial product placed at its chunk position, wrapping mod 2^96
    always_comb
    begin
        case (add_chunk_reg)
            tspc_pkg::CHUNK_LO:  term = tspc_pkg::ACC_W'(prod_reg);
            tspc_pkg::CHUNK_MID: term = tspc_pkg::ACC_W'(prod_reg) << tspc_pkg::CHUNK_W;
            tspc_pkg::CHUNK_HI:  term = tspc_pkg::ACC_W'(prod_reg) << (2 * tspc_pkg::CHUNK_W);
            default:             term = '0;
        endcase
    end

    assign base     = add_clear_reg ? '0 : sum_reg;
    assign sum_next = add_neg_reg ? (base - term) : (base + term);

    // dividend over 2^19, then divided by 5^19; the estimate is exact or one low
    assign y_val     = rem_reg[tspc_pkg::Y_LSB +: tspc_pkg::Y_W];
    assign est       = tspc_pkg::SCALE_W'(rem_reg[tspc_pkg::YT_LSB +: tspc_pkg::CHUNK_W])
                       * tspc_pkg::SCALE_W'(tspc_pkg::RECIP);
    assign back_next = (tspc_pkg::SCALE_W'(back_hi_reg) << tspc_pkg::CHUNK_W)
                       + tspc_pkg::SCALE_W'(back_lo_reg) + tspc_pkg::DIV_ODD;
    assign q_low     = tspc_pkg::SCALE_W'(y_val) >= back_next;

    // saturate the rounded magnitude back into a signed word
    always_comb
    begin
        if (neg_reg)
        begin
            clip = over_reg || (q_reg > tspc_pkg::TEMP_MIN_MAG);
            temp = clip ? tspc_pkg::TEMP_W'(tspc_pkg::TEMP_MIN_MAG)
                        : tspc_pkg::TEMP_W'(tspc_pkg::Q_W'(0) - q_reg);
        end
        else
        begin
            clip = over_reg || (q_reg > tspc_pkg::TEMP_MAX_MAG);
            temp = clip ? tspc_pkg::TEMP_W'(tspc_pkg::TEMP_MAX_MAG)
                        : tspc_pkg::TEMP_W'(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_en_reg <= 1'b0;
        end
        else
        begin
            add_en_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sensor_reg <= in_sensor;
            a_reg      <= in_reading[tspc_pkg::ADC_W-1 -: tspc_pkg::A_W];
            acc_reg    <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg      <= product;
            add_clear_reg <= cmd.clear;
            add_neg_reg   <= cmd.neg;
            add_last_reg  <= cmd.last;
            add_chunk_reg <= cmd.chunk;
        end
        if (add_en_reg)
        begin
            sum_reg <= sum_next;
            if (add_last_reg)
            begin
                acc_reg <= sum_next;
            end
        end
        // magnitude plus half a unit, two's complement negate folded into the add
        if (cmd.abs_en)
        begin
            neg_reg <= acc_reg[tspc_pkg::ACC_W-1];
            rem_reg <= acc_reg[tspc_pkg::ACC_W-1] ? (~acc_reg + HALF_P1) : (acc_reg + HALF);
        end
        if (cmd.ovchk_en)
        begin
            over_reg <= rem_reg >= DIV_LIMIT;
        end
        if (cmd.recip_en)
        begin
            q_reg <= est[tspc_pkg::RECIP_SHIFT +: tspc_pkg::Q_W];
        end
        // estimate times 5^19 as two partial products
        if (cmd.back_en)
        begin
            back_lo_reg <= tspc_pkg::BACK_LO_W'(q_reg)
                           * tspc_pkg::BACK_LO_W'(tspc_pkg::DIV_ODD_LO);
            back_hi_reg <= tspc_pkg::BACK_HI_W'(q_reg)
                           * tspc_pkg::BACK_HI_W'(tspc_pkg::DIV_ODD_HI);
        end
        if (cmd.fix_en)
        begin
            if (q_low)
            begin
                q_reg <= q_reg + tspc_pkg::Q_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_sensor_reg <= sensor_reg;
            out_temp_reg   <= temp;
            out_clip_reg   <= clip;
        end
    end

    assign cur_sensor  = sensor_reg;
    assign out_sensor  = out_sensor_reg;
    assign out_temp    = out_temp_reg;
    assign out_clipped = out_clip_reg;

endmodule

// ===== src/tspc_ctrl.sv =====
// sequencer for polynomial steps, rounding division and the result beat
module tspc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tspc_pkg::tspc_cmd_t  cmd
);

    tspc_pkg::ctrl_state_t state_reg;
    tspc_pkg::ctrl_state_t state_next;
    logic [tspc_pkg::STEP_W-1:0]  step_reg;
    logic [tspc_pkg::STEP_W-1:0]  step_next;
    logic [tspc_pkg::PHASE_W-1:0] phase_reg;
    logic [tspc_pkg::PHASE_W-1:0] phase_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tspc_pkg::PHASE_W-1:0] coef_phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tspc_pkg::ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            tspc_pkg::ST_IDLE:
            begin
                if (in_valid && (in_kind == tspc_pkg::KIND_CONVERT))
                begin
                    state_next = tspc_pkg::ST_POLY;
                    step_next  = tspc_pkg::STEP_TOP;
                    phase_next = tspc_pkg::PHASE_FIRST;
                end
            end
            tspc_pkg::ST_POLY:
            begin
                if (phase_reg == tspc_pkg::PHASE_LAST)
                begin
                    phase_next = tspc_pkg::PHASE_FIRST;
                    if (step_reg == '0)
                    begin
                        state_next = tspc_pkg::ST_ABS;
                    end
                    else
                    begin
                        step_next = step_reg - tspc_pkg::STEP_W'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + tspc_pkg::PHASE_W'(1);
                end
            end
            tspc_pkg::ST_ABS:
            begin
                state_next = tspc_pkg::ST_OVCHK;
            end
            tspc_pkg::ST_OVCHK:
            begin
                state_next = tspc_pkg::ST_RECIP;
            end
            tspc_pkg::ST_RECIP:
            begin
                state_next = tspc_pkg::ST_BACK;
            end
            tspc_pkg::ST_BACK:
            begin
                state_next = tspc_pkg::ST_FIX;
            end
            tspc_pkg::ST_FIX:
            begin
                state_next = tspc_pkg::ST_FINISH;
            end
            tspc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tspc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tspc_pkg::ST_IDLE;
            end
        endcase
    end

    assign coef_phase = phase_reg - tspc_pkg::PHASE_COEF;

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.step = step_reg;
        in_ready = 1'b0;
        case (state_reg)
            tspc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid && (in_kind == tspc_pkg::KIND_CONVERT);
            end
            tspc_pkg::ST_POLY:
            begin
                // phases 0-2: acc chunks times a, 3-4: scale chunks times k, 5: drain
                cmd.rd_en   = phase_reg == tspc_pkg::PHASE_FIRST;
                cmd.mul_en  = phase_reg <= tspc_pkg::PHASE_LAST_MUL;
                cmd.mul_src = (phase_reg >= tspc_pkg::PHASE_COEF) ? tspc_pkg::SRC_COEF
                                                                  : tspc_pkg::SRC_ACC;
                cmd.chunk   = (phase_reg >= tspc_pkg::PHASE_COEF) ? coef_phase[1:0]
                                                                  : phase_reg[1:0];
                cmd.clear   = phase_reg == tspc_pkg::PHASE_FIRST;
                cmd.neg     = (phase_reg >= tspc_pkg::PHASE_COEF)
                              && tspc_pkg::scale_is_negative(step_reg);
                cmd.last    = phase_reg == tspc_pkg::PHASE_LAST_MUL;
            end
            tspc_pkg::ST_ABS:
            begin
                cmd.abs_en = 1'b1;
            end
            tspc_pkg::ST_OVCHK:
            begin
                cmd.ovchk_en = 1'b1;
            end
            tspc_pkg::ST_RECIP:
            begin
                cmd.recip_en = 1'b1;
            end
            tspc_pkg::ST_BACK:
            begin
                cmd.back_en = 1'b1;
            end
            tspc_pkg::ST_FIX:
            begin
                cmd.fix_en = 1'b1;
            end
            tspc_pkg::ST_FINISH:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/temp_sensor_poly_conversion_unit.sv =====
// top level of the temperature polynomial conversion unit
// load beats are accepted one per cycle, back to back, while no convert is in progress
// a convert beat runs five horner steps on one shared 32x16 multiplier, then magnitude,
// range check and a reciprocal divide by 1e19 (estimate, back-multiply, correction), then
// loads the result register; no new beat is accepted until that result has been loaded
// asynchronous active-low reset clears the calibration store valid bits and the control state
module temp_sensor_poly_conversion_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sensor, coef_index, coef_value, adc_reading, zero pad
    input  logic [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sensor_echo, temperature_centi, zero pad
    output logic [0:0]  m_axis_tuser    // clipped
);

    tspc_pkg::tspc_cmd_t cmd;

    logic [tspc_pkg::SENSOR_W-1:0]       in_sensor;
    logic [tspc_pkg::IDX_W-1:0]          in_index;
    logic [tspc_pkg::COEF_W-1:0]         in_value;
    logic [tspc_pkg::ADC_W-1:0]          in_reading;
    logic                                in_kind;
    logic                                load_wr;
    logic [tspc_pkg::COEF_W-1:0]         coef;
    logic [tspc_pkg::SENSOR_W-1:0]       cur_sensor;
    logic [tspc_pkg::SENSOR_W-1:0]       out_sensor;
    logic signed [tspc_pkg::TEMP_W-1:0]  out_temp;
    logic                                out_clipped;

    assign in_sensor  = s_axis_tdata[2:0];
    assign in_index   = s_axis_tdata[5:3];
    assign in_value   = s_axis_tdata[21:6];
    assign in_reading = s_axis_tdata[45:22];
    assign in_kind    = s_axis_tuser[0];

    // a load beat writes the store on its accepting edge
    assign load_wr = s_axis_tvalid && s_axis_tready && (in_kind == tspc_pkg::KIND_LOAD);

    tspc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (in_kind),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    tspc_coef_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_wr),
        .wr_sensor (in_sensor),
        .wr_index  (in_index),
        .wr_value  (in_value),
        .rd_en     (cmd.rd_en),
        .rd_sensor (cur_sensor),
        .rd_index  (cmd.step),
        .rd_data   (coef)
    );

    tspc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_sensor   (in_sensor),
        .in_reading  (in_reading),
        .coef        (coef),
        .cur_sensor  (cur_sensor),
        .out_sensor  (out_sensor),
        .out_temp    (out_temp),
        .out_clipped (out_clipped)
    );

    assign m_axis_tdata = {5'b0, out_temp, out_sensor};
    assign m_axis_tuser = out_clipped;

endmodule

// ===== sim/temp_sensor_poly_conversion_unit_tb.sv =====
// testbench for the temperature polynomial conversion unit: directed and random beats, scoreboard
module temp_sensor_poly_conversion_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tspc_pkg::*;

    typedef enum logic [2:0] {
        CAL_K0,
        CAL_K1,
        CAL_K2,
        CAL_K3,
        CAL_K4,
        CAL_BAD5,
        CAL_BAD6,
        CAL_BAD7
    } cal_idx_t;

    typedef struct packed {
        logic [SENSOR_W-1:0]        sensor;
        logic signed [TEMP_W-1:0]   temp;
        logic                       clipped;
    } centi_result_t;

    localparam logic [127:0] TEMP_HI_MAG = 128'd32767;
    localparam logic [127:0] TEMP_LO_MAG = 128'd32768;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // sensor, coef_index, coef_value, adc_reading, zero pad
    logic [0:0]  s_axis_tuser = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // sensor_echo, temperature_centi, zero pad
    logic [0:0]  m_axis_tuser;         // clipped

    logic [COEF_W-1:0] cal_words [SENSORS][COEFS];
    centi_result_t     pending_temps [$];
    int                mismatches = 0;
    int                items_sent = 0;
    int                idle_pct = 11;

    temp_sensor_poly_conversion_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // exact polynomial on 128-bit magnitudes, rounded half away from zero, then saturated
    function automatic centi_result_t convert_to_centi(input logic [SENSOR_W-1:0] sensor,
                                                       input logic [ADC_W-1:0] reading);
        logic [127:0] a, k0, k1, k2, k3, k4;
        logic [127:0] pos, neg, diff, mag;
        logic         negative;
        centi_result_t r;
        k0 = '0; k1 = '0; k2 = '0; k3 = '0; k4 = '0;
        if (int'(sensor) < SENSORS)
        begin
            k0 = 128'(cal_words[sensor][CAL_K0]);
            k1 = 128'(cal_words[sensor][CAL_K1]);
            k2 = 128'(cal_words[sensor][CAL_K2]);
            k3 = 128'(cal_words[sensor][CAL_K3]);
            k4 = 128'(cal_words[sensor][CAL_K4]);
        end
        a = 128'(reading[ADC_W-1:8]);
        pos = 128'd400000 * k3 * a * a * a + 128'd1000000000000000 * k1 * a;
        neg = 128'd2 * k4 * a * a * a * a + 128'd20000000000 * k2 * a * a
            + 128'd15000000000000000000 * k0;
        negative = neg > pos;
        diff = negative ? neg - pos : pos - neg;
        mag = (diff + 128'd5000000000000000000) / 128'd10000000000000000000;
        r.sensor = sensor;
        r.clipped = 1'b0;
        if (negative)
        begin
            if (mag > TEMP_LO_MAG)
            begin
                mag = TEMP_LO_MAG;
                r.clipped = 1'b1;
            end
            r.temp = TEMP_W'(-mag);
        end
        else
        begin
            if (mag > TEMP_HI_MAG)
            begin
                mag = TEMP_HI_MAG;
                r.clipped = 1'b1;
            end
            r.temp = TEMP_W'(mag);
        end
        return r;
    endfunction

    // typical factory calibration, used as the center of realistic random sets
    function automatic logic [COEF_W-1:0] typical_word(input cal_idx_t idx);
        case (idx)
            CAL_K0:  return 16'd40781;
            CAL_K1:  return 16'd32791;
            CAL_K2:  return 16'd36016;
            CAL_K3:  return 16'd24926;
            default: return 16'd28446;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_word(input int flavor, input cal_idx_t idx);
        case (flavor)
            0:       return typical_word(idx) + 16'($urandom_range(0, 2047)) - 16'd1024;
            1:       return 16'($urandom_range(0, 255));
            2:       return 16'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // one input beat; valid stays high into the next call unless an idle gap is drawn
    task automatic send_beat(input logic kind, input logic [SENSOR_W-1:0] sensor,
                             input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value,
                             input logic [ADC_W-1:0] reading);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, reading, value, idx, sensor};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == KIND_LOAD)
        begin
            if (int'(idx) < COEFS)
            begin
                cal_words[sensor][idx] = value;
                items_sent++;
            end
        end
        else
        begin
            pending_temps.push_back(convert_to_centi(sensor, reading));
            items_sent++;
        end
    endtask

    task automatic load_word(input logic [SENSOR_W-1:0] sensor, input cal_idx_t idx,
                             input logic [COEF_W-1:0] value);
        send_beat(KIND_LOAD, sensor, idx, value, ADC_W'($urandom));
    endtask

    task automatic convert(input logic [SENSOR_W-1:0] sensor, input logic [ADC_W-1:0] reading);
        send_beat(KIND_CONVERT, sensor, IDX_W'($urandom), COEF_W'($urandom), reading);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
    endtask

    // result side: random backpressure, compare each beat with the oldest expectation
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin
        centi_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.sensor  = m_axis_tdata[2:0];
            got.temp    = m_axis_tdata[18:3];
            got.clipped = m_axis_tuser[0];
            if (pending_temps.size() == 0)
                report($sformatf("unexpected result: sensor %0d temp %0d clipped %0b",
                                 got.sensor, got.temp, got.clipped));
            else
            begin
                want = pending_temps.pop_front();
                if (got.sensor !== want.sensor || got.temp !== want.temp
                    || got.clipped !== want.clipped)
                    report($sformatf("mismatch: exp sensor %0d temp %0d clipped %0b, got sensor %0d temp %0d clipped %0b",
                                     want.sensor, want.temp, want.clipped,
                                     got.sensor, got.temp, got.clipped));
            end
        end
    end

    task automatic test_cleared_store();
        convert(3'd0, 24'hFFFFFF);
        convert(3'd7, 24'h000000);
    endtask

    // -1.5 rounds to -2 and 0.5 rounds to 1
    task automatic test_rounding_ties();
        load_word(3'd0, CAL_K0, 16'd1);
        convert(3'd0, 24'h000000);
        load_word(3'd1, CAL_K1, 16'd5000);
        convert(3'd1, 24'h0001FF);
    endtask

    task automatic test_saturation();
        load_word(3'd0, CAL_K0, 16'd21845);
        convert(3'd0, ADC_W'($urandom));
        load_word(3'd0, CAL_K0, 16'd21846);
        convert(3'd0, ADC_W'($urandom));
        load_word(3'd1, CAL_K1, 16'd32767);
        convert(3'd1, {16'd10000, 8'hFF});
        convert(3'd1, {16'd10001, 8'h00});
    endtask

    task automatic test_ignored_loads();
        load_word(3'd1, CAL_BAD5, 16'hFFFF);
        load_word(3'd1, CAL_BAD6, 16'hFFFF);
        load_word(3'd1, CAL_BAD7, 16'hFFFF);
        convert(3'd1, {16'd10000, 8'h00});
    endtask

    task automatic test_extreme_words();
        load_word(3'd7, CAL_K0, 16'hFFFF);
        load_word(3'd7, CAL_K1, 16'hFFFF);
        load_word(3'd7, CAL_K2, 16'hFFFF);
        load_word(3'd7, CAL_K3, 16'hFFFF);
        load_word(3'd7, CAL_K4, 16'hFFFF);
        convert(3'd7, 24'hFFFFFF);
        convert(3'd7, 24'h000000);
    endtask

    // mostly full calibration sets followed by conversions, some partial rewrites and noise
    task automatic test_random_sessions(input int n_items);
        int stop_at, flavor, roll, n_conv;
        logic [SENSOR_W-1:0] sensor, conv_sensor;
        logic [ADC_W-1:0] reading;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            sensor = SENSOR_W'($urandom_range(0, SENSORS - 1));
            roll = $urandom_range(0, 9);
            flavor = $urandom_range(0, 9);
            flavor = (flavor < 5) ? 0 : (flavor < 7) ? 1 : (flavor < 9) ? 2 : 3;
            if (roll < 8)
            begin
                for (int i = 0; i < COEFS; i++)
                    load_word(sensor, cal_idx_t'(i), pick_word(flavor, cal_idx_t'(i)));
            end
            else if (roll == 8)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    cal_idx_t idx;
                    idx = cal_idx_t'($urandom_range(0, COEFS - 1));
                    load_word(sensor, idx, pick_word(flavor, idx));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    load_word(SENSOR_W'($urandom), cal_idx_t'($urandom_range(0, 7)),
                              COEF_W'($urandom));
            end
            n_conv = $urandom_range(1, 6);
            repeat (n_conv)
            begin
                conv_sensor = ($urandom_range(0, 9) < 8) ? sensor : SENSOR_W'($urandom);
                reading = ($urandom_range(0, 1) != 0) ? ADC_W'($urandom_range(24'h600000, 24'hB00000))
                                                      : ADC_W'($urandom);
                convert(conv_sensor, reading);
            end
        end
    endtask

    task automatic test_no_idle_stretch(input int n_items);
        idle_pct = 0;
        test_random_sessions(n_items);
        idle_pct = 11;
    endtask

    // sender holds off until every conversion in flight has come back
    task automatic test_drain_pause();
        convert(3'd2, ADC_W'($urandom));
        convert(3'd5, ADC_W'($urandom));
        wait_drained();
        convert(3'd2, ADC_W'($urandom));
    endtask

    initial
    begin
        for (int s = 0; s < SENSORS; s++)
            for (int c = 0; c < COEFS; c++)
                cal_words[s][c] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_store();
        test_rounding_ties();
        test_saturation();
        test_ignored_loads();
        test_extreme_words();
        test_random_sessions(550);
        test_drain_pause();
        test_no_idle_stretch(250);
        test_drain_pause();
        test_random_sessions(420);

        s_axis_tvalid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_temps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
